// ----- hdl/pida_pkg.sv -----
// Package for the positional insert/delete array.
// Holds the action and status codes, the cell command type and the default capacity.
// No dependencies.
package pida_pkg;

    localparam int CAPACITY_DEFAULT = 32;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 6;
    localparam int WORD_W     = 32;
    localparam int FILL_W     = 6;
    localparam int STATUS_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE
    } cell_cmd_t;

endpackage

// ----- hdl/pida_cell.sv -----
// One storage cell of the positional insert/delete array.
// Loads the new word, takes its lower or upper neighbor's word, or holds.
// Depends on pida_pkg.
module pida_cell #(
    parameter int PW  = 7,
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  pida_pkg::cell_cmd_t                cmd,
    input  logic [PW-1:0]                      index,
    input  logic signed [pida_pkg::WORD_W-1:0] value,
    input  logic signed [pida_pkg::WORD_W-1:0] left_word,
    input  logic signed [pida_pkg::WORD_W-1:0] right_word,
    output logic signed [pida_pkg::WORD_W-1:0] word
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [pida_pkg::WORD_W-1:0] word_reg;
    logic signed [pida_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (cmd)
            pida_pkg::CELL_APPEND:
            begin
                if (index == MY_IDX)
                begin
                    word_next = value;
                end
            end
            pida_pkg::CELL_INSERT:
            begin
                if (index == MY_IDX)
                begin
                    word_next = value;
                end
                else if (index < MY_IDX)
                begin
                    word_next = left_word;
                end
            end
            pida_pkg::CELL_DELETE:
            begin
                if (index <= MY_IDX)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- hdl/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array.
// Instantiates a row of pida_cell storage cells; depends on pida_pkg.
//
// Usage: each input word carries an action (clear, append, read, insert,
// delete), a 1-based position and a value. Every accepted input word gives
// exactly one output word with the data read or deleted, the fill after the
// operation and a status code.
// The list lives in a row of cells. On insert every cell above the position
// takes its lower neighbor's word while the cell at the position loads the
// value; on delete every cell from the position up takes its upper
// neighbor's word. All cells move in the same cycle.
// The result is registered: it is loaded into the output register at the
// edge that accepts the input word and can be taken from the next edge on.
// Throughput is one word per cycle, set by the single output register, while
// the receiver does not stall.
// When the receiver stalls, the result waits in the output register and
// in_stall rises until it is taken; the list does not change meanwhile.
// Reset empties the list and clears the output valid flag; no clearing
// pass is needed, since only entries below the fill are ever read.
module positional_insert_delete_array #(
    parameter int CAPACITY = pida_pkg::CAPACITY_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pida_pkg::ACTION_W-1:0]        action,
    input  logic [pida_pkg::POSITION_W-1:0]      position,
    input  logic signed [pida_pkg::WORD_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pida_pkg::WORD_W-1:0]   data,
    output logic [pida_pkg::FILL_W-1:0]          fill,
    output logic [pida_pkg::STATUS_W-1:0]        status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > pida_pkg::POSITION_W + 1) ? CW : pida_pkg::POSITION_W + 1;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic signed [pida_pkg::WORD_W-1:0] data_reg;
    logic signed [pida_pkg::WORD_W-1:0] data_next;
    logic [pida_pkg::FILL_W-1:0]        fill_reg;
    logic [pida_pkg::FILL_W-1:0]        fill_next;
    logic [pida_pkg::STATUS_W-1:0]      status_reg;
    logic [pida_pkg::STATUS_W-1:0]      status_next;

    logic                accept;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       count_ext;
    logic [PW-1:0]       slot_idx;
    logic [PW-1:0]       cell_index;
    logic                pos_nonzero;
    logic                read_ok;
    logic                insert_ok;
    logic                full;
    pida_pkg::cell_cmd_t cmd;
    logic signed [pida_pkg::WORD_W-1:0] words [CAPACITY];
    logic signed [pida_pkg::WORD_W-1:0] read_word;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign pos_ext     = PW'(position);
    assign count_ext   = PW'(count_reg);
    assign slot_idx    = pos_ext - PW'(1);
    assign pos_nonzero = (position != '0);
    assign read_ok     = pos_nonzero && (pos_ext <= count_ext);
    assign insert_ok   = pos_nonzero && (pos_ext <= count_ext + PW'(1));
    assign full        = (count_ext == PW'(CAPACITY));
    assign read_word   = words[slot_idx[IW-1:0]];

    always_comb
    begin
        cmd         = pida_pkg::CELL_HOLD;
        cell_index  = slot_idx;
        count_next  = count_reg;
        data_next   = '0;
        status_next = pida_pkg::ST_OK;
        unique case (action)
            pida_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            pida_pkg::ACT_APPEND:
            begin
                cell_index = count_ext;
                if (full)
                begin
                    status_next = pida_pkg::ST_FULL;
                end
                else
                begin
                    cmd        = pida_pkg::CELL_APPEND;
                    count_next = count_reg + CW'(1);
                end
            end
            pida_pkg::ACT_READ:
            begin
                if (read_ok)
                begin
                    data_next = read_word;
                end
                else
                begin
                    status_next = pida_pkg::ST_RANGE;
                end
            end
            pida_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = pida_pkg::ST_FULL;
                end
                else if (!insert_ok)
                begin
                    status_next = pida_pkg::ST_RANGE;
                end
                else
                begin
                    cmd        = pida_pkg::CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pida_pkg::ACT_DELETE:
            begin
                if (read_ok)
                begin
                    data_next  = read_word;
                    cmd        = pida_pkg::CELL_DELETE;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = pida_pkg::ST_RANGE;
                end
            end
            default:
            begin
                cmd = pida_pkg::CELL_HOLD;
            end
        endcase
        if (!accept)
        begin
            cmd        = pida_pkg::CELL_HOLD;
            count_next = count_reg;
        end
        fill_next = pida_pkg::FILL_W'(count_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            fill_reg   <= fill_next;
            status_reg <= status_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [pida_pkg::WORD_W-1:0] left_word;
        logic signed [pida_pkg::WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = value;
        end
        else
        begin : g_mid_left
            assign left_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = words[i];
        end
        else
        begin : g_mid_right
            assign right_word = words[i+1];
        end

        pida_cell #(
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .index      (cell_index),
            .value      (value),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign fill      = fill_reg;
    assign status    = status_reg;

endmodule

// ----- tb/sv/tb_positional_insert_delete_array.sv -----
// Self-checking testbench for positional_insert_delete_array: directed and random
// list operations with random idling on both channels, checked by a scoreboard.
// Depends on pida_pkg and the positional_insert_delete_array RTL.
module tb_positional_insert_delete_array;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = pida_pkg::CAPACITY_DEFAULT;

    class list_scoreboard;
        typedef struct packed {
            logic signed [pida_pkg::WORD_W-1:0] data;
            logic [pida_pkg::FILL_W-1:0]        fill;
            logic [pida_pkg::STATUS_W-1:0]      status;
        } list_result_t;

        logic signed [pida_pkg::WORD_W-1:0] cells [CAPACITY];
        int                                 count;
        int                                 mismatches;
        list_result_t                       expected_results [$];

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function int entries();
            return count;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_word(logic [pida_pkg::ACTION_W-1:0] act,
                                logic [pida_pkg::POSITION_W-1:0] pos,
                                logic signed [pida_pkg::WORD_W-1:0] val);
            list_result_t r;
            int p;
            int i;
            p = int'(pos);
            r.data = '0;
            r.status = pida_pkg::ST_OK;
            case (act)
                pida_pkg::ACT_CLEAR:
                begin
                    count = 0;
                end
                pida_pkg::ACT_APPEND:
                begin
                    if (count >= CAPACITY)
                    begin
                        r.status = pida_pkg::ST_FULL;
                    end
                    else
                    begin
                        cells[count] = val;
                        count++;
                    end
                end
                pida_pkg::ACT_READ:
                begin
                    if (p == 0 || p > count)
                    begin
                        r.status = pida_pkg::ST_RANGE;
                    end
                    else
                    begin
                        r.data = cells[p-1];
                    end
                end
                pida_pkg::ACT_INSERT:
                begin
                    if (count >= CAPACITY)
                    begin
                        r.status = pida_pkg::ST_FULL;
                    end
                    else if (p == 0 || p > count + 1)
                    begin
                        r.status = pida_pkg::ST_RANGE;
                    end
                    else
                    begin
                        for (i = count; i >= p; i--)
                        begin
                            cells[i] = cells[i-1];
                        end
                        cells[p-1] = val;
                        count++;
                    end
                end
                pida_pkg::ACT_DELETE:
                begin
                    if (p == 0 || p > count)
                    begin
                        r.status = pida_pkg::ST_RANGE;
                    end
                    else
                    begin
                        r.data = cells[p-1];
                        for (i = p - 1; i + 1 < count; i++)
                        begin
                            cells[i] = cells[i+1];
                        end
                        count--;
                    end
                end
                default:
                begin
                end
            endcase
            r.fill = pida_pkg::FILL_W'(count);
            expected_results.push_back(r);
        endfunction

        function void check_word(logic signed [pida_pkg::WORD_W-1:0] data,
                                 logic [pida_pkg::FILL_W-1:0] fill,
                                 logic [pida_pkg::STATUS_W-1:0] status);
            list_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("output word with no expected result: data %0d fill %0d status %0d",
                       data, fill, status);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (data !== e.data)
            begin
                $error("data: expected %0d, actual %0d", e.data, data);
                mismatches++;
            end
            if (fill !== e.fill)
            begin
                $error("fill: expected %0d, actual %0d", e.fill, fill);
                mismatches++;
            end
            if (status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [pida_pkg::ACTION_W-1:0]        action;
    logic [pida_pkg::POSITION_W-1:0]      position;
    logic signed [pida_pkg::WORD_W-1:0]   value;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [pida_pkg::WORD_W-1:0]   data;
    logic [pida_pkg::FILL_W-1:0]          fill;
    logic [pida_pkg::STATUS_W-1:0]        status;

    list_scoreboard sb = new();
    bit             calm = 1'b0;

    positional_insert_delete_array i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .fill      (fill),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("positional_insert_delete_array regression: fail");
        $finish;
    end

    task automatic send_word(input logic [pida_pkg::ACTION_W-1:0] act,
                             input logic [pida_pkg::POSITION_W-1:0] pos,
                             input logic signed [pida_pkg::WORD_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        action = act;
        position = pos;
        value = val;
        do @(posedge clk); while (in_stall);
        sb.note_word(act, pos, val);
    endtask

    function automatic logic signed [pida_pkg::WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return signed'($urandom());
        endcase
    endfunction

    task automatic send_random_word(input bit grow);
        int r;
        int n;
        logic [pida_pkg::ACTION_W-1:0]   act;
        logic [pida_pkg::POSITION_W-1:0] pos;
        n = sb.entries();
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            act = pida_pkg::ACTION_W'($urandom_range(0, 7));
            pos = pida_pkg::POSITION_W'($urandom_range(0, 63));
        end
        else
        begin
            if (r < 6)
            begin
                act = pida_pkg::ACT_CLEAR;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (grow)
                begin
                    act = (r < 30) ? pida_pkg::ACT_APPEND :
                          (r < 60) ? pida_pkg::ACT_INSERT :
                          (r < 82) ? pida_pkg::ACT_READ : pida_pkg::ACT_DELETE;
                end
                else
                begin
                    act = (r < 10) ? pida_pkg::ACT_APPEND :
                          (r < 20) ? pida_pkg::ACT_INSERT :
                          (r < 50) ? pida_pkg::ACT_READ : pida_pkg::ACT_DELETE;
                end
            end
            if ($urandom_range(0, 9) == 0 || n == 0)
            begin
                pos = pida_pkg::POSITION_W'($urandom_range(0, 63));
            end
            else if (act == pida_pkg::ACT_INSERT)
            begin
                pos = pida_pkg::POSITION_W'($urandom_range(1, n + 1));
            end
            else
            begin
                pos = pida_pkg::POSITION_W'($urandom_range(1, n));
            end
        end
        send_word(act, pos, pick_value());
    endtask

    initial
    begin
        int n;
        int phase_len;
        int waited;
        bit grow;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = pida_pkg::ACT_CLEAR;
        position = '0;
        value = '0;
        out_stall = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(pida_pkg::ACT_READ, 6'd1, 32'sd5);
        send_word(pida_pkg::ACT_DELETE, 6'd1, 32'sd5);
        send_word(pida_pkg::ACT_APPEND, 6'd0, 32'sh8000_0000);
        send_word(pida_pkg::ACT_APPEND, 6'd63, 32'sh7fff_ffff);
        send_word(pida_pkg::ACT_APPEND, 6'd1, -32'sd1);
        send_word(pida_pkg::ACT_APPEND, 6'd2, 32'sd0);
        send_word(pida_pkg::ACT_READ, 6'd0, 32'sd0);
        send_word(pida_pkg::ACT_READ, 6'd1, 32'sd0);
        send_word(pida_pkg::ACT_READ, 6'd4, 32'sd0);
        send_word(pida_pkg::ACT_READ, 6'd5, 32'sd0);
        send_word(pida_pkg::ACT_INSERT, 6'd1, 32'sh1234_5678);
        send_word(pida_pkg::ACT_INSERT, 6'd6, -32'sd7);
        send_word(pida_pkg::ACT_INSERT, 6'd8, 32'sd9);
        send_word(pida_pkg::ACT_INSERT, 6'd0, 32'sd9);
        send_word(pida_pkg::ACT_INSERT, 6'd3, 32'sh5555_aaaa);
        send_word(pida_pkg::ACT_READ, 6'd63, 32'sd0);
        send_word(pida_pkg::ACT_DELETE, 6'd0, 32'sd0);
        send_word(pida_pkg::ACT_DELETE, 6'd1, 32'sd0);
        send_word(pida_pkg::ACT_DELETE, pida_pkg::POSITION_W'(sb.entries()), 32'sd0);
        send_word(pida_pkg::ACT_DELETE, 6'd2, 32'sd0);
        send_word(pida_pkg::ACT_DELETE + 3'd1, 6'd63, -32'sd1);
        send_word(pida_pkg::ACT_DELETE + 3'd2, 6'd0, 32'sd0);
        send_word(pida_pkg::ACT_DELETE + 3'd3, 6'd21, 32'sh0f0f_0f0f);
        send_word(pida_pkg::ACT_CLEAR, 6'd63, -32'sd1);
        send_word(pida_pkg::ACT_READ, 6'd1, 32'sd0);

        n = 0;
        while (n < 2000)
        begin
            phase_len = $urandom_range(40, 160);
            grow = 1'($urandom_range(0, 1));
            calm = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                send_random_word(grow);
                n++;
            end
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid = 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
        end
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("positional_insert_delete_array regression: pass");
        end
        else
        begin
            $display("positional_insert_delete_array regression: fail");
        end
        $finish;
    end

    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 15);
            repeat (n)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_word(data, fill, status);
        end
    end

endmodule
